@@ sv/trd_pkg.sv @@
// trd_pkg: shared constants, types and command structures for the tracker record deframer
// used by trd_ctrl, trd_datapath and tracker_record_deframer_unit
`default_nettype none
package trd_pkg;

    localparam int WORDS_PER_RECORD = 12;
    localparam int MAX_RECEIVERS    = 16;

    localparam int BYTE_W   = 8;
    localparam int LOW7_W   = 7;
    localparam int WORD_W   = 2 * LOW7_W;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int ADDR_W   = 4;
    localparam int OUT_IDX_W = 4;
    localparam int VALUE_W  = 16;

    localparam int POS_W  = $clog2(2 * WORDS_PER_RECORD + 2);
    localparam int WIDX_W = (WORDS_PER_RECORD > 1) ? $clog2(WORDS_PER_RECORD) : 1;
    localparam int CNT_W  = $clog2(WORDS_PER_RECORD + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ADDR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RECEIVER_CNT  = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_FIRST,
        PH_NEXT
    } t_phase;

    typedef enum logic {
        ST_ACCEPT,
        ST_EMIT
    } t_seq_state;

    typedef struct packed {
        logic              load_low;
        logic              write_word;
        logic [WIDX_W-1:0] word_idx;
        logic              load_button;
        logic              arm;
        logic              frame_end;
        logic              emit;
    } t_dp_cmd;

    typedef struct packed {
        logic emit_pending;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

@@ sv/trd_ctrl.sv @@
// trd_ctrl: sequencing state machine, frame phase tracking and configuration registers
// depends on trd_pkg
`default_nettype none
module trd_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output      logic                           o_stall,
    input  wire logic [trd_pkg::BYTE_W-1:0]     i_rx_byte,
    input  wire logic                           i_cfg_valid,
    input  wire logic [trd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [trd_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire trd_pkg::t_dp_status            i_status,
    output      trd_pkg::t_dp_cmd               o_cmd
);

    trd_pkg::t_seq_state r_state, n_state;
    trd_pkg::t_phase     r_phase, n_phase;
    logic [trd_pkg::POS_W-1:0] r_pos, n_pos;
    logic [trd_pkg::CFG_W-1:0] r_records, n_records;
    logic [trd_pkg::CFG_W-1:0] r_cfg_addr;
    logic [trd_pkg::CFG_W-1:0] r_cfg_count;
    logic [trd_pkg::CFG_W-1:0] w_count_eff;
    logic                      w_accept;

    assign w_accept    = (r_state == trd_pkg::ST_ACCEPT) && i_valid;
    assign o_stall     = (r_state != trd_pkg::ST_ACCEPT);
    assign w_count_eff = (r_cfg_count == '0) ? trd_pkg::CFG_W'(1) : r_cfg_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= trd_pkg::ST_ACCEPT;
            r_phase     <= trd_pkg::PH_HUNT;
            r_pos       <= '0;
            r_records   <= '0;
            r_cfg_addr  <= trd_pkg::CFG_W'(1);
            r_cfg_count <= trd_pkg::CFG_W'(1);
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_records <= n_records;
            if (i_cfg_valid && (i_cfg_index == trd_pkg::CFG_EXPECTED_ADDR)) begin
                r_cfg_addr <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == trd_pkg::CFG_RECEIVER_CNT)) begin
                r_cfg_count <= i_cfg_data;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            trd_pkg::ST_ACCEPT: begin
                if (i_valid) begin
                    n_state = trd_pkg::ST_EMIT;
                end
            end
            trd_pkg::ST_EMIT: begin
                if (!i_status.emit_pending || i_status.out_free) begin
                    n_state = trd_pkg::ST_ACCEPT;
                end
            end
            default: n_state = trd_pkg::ST_ACCEPT;
        endcase
    end

    // outputs and frame tracking
    always_comb begin
        o_cmd     = '0;
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_records = r_records;
        o_cmd.word_idx = trd_pkg::WIDX_W'(r_pos >> 1);
        if (r_state == trd_pkg::ST_EMIT) begin
            o_cmd.emit = i_status.emit_pending && i_status.out_free;
        end
        if (w_accept) begin
            case (r_phase)
                trd_pkg::PH_HUNT: begin
                    if (i_rx_byte[trd_pkg::BYTE_W-1]) begin
                        o_cmd.load_low = 1'b1;
                        n_pos          = trd_pkg::POS_W'(1);
                        n_phase        = trd_pkg::PH_FIRST;
                    end
                end
                default: begin
                    if (r_pos < trd_pkg::POS_W'(2 * trd_pkg::WORDS_PER_RECORD)) begin
                        o_cmd.load_low   = ~r_pos[0];
                        o_cmd.write_word = r_pos[0];
                        n_pos            = r_pos + trd_pkg::POS_W'(1);
                    end else if (r_pos == trd_pkg::POS_W'(2 * trd_pkg::WORDS_PER_RECORD)) begin
                        o_cmd.load_button = 1'b1;
                        n_pos             = r_pos + trd_pkg::POS_W'(1);
                    end else begin
                        n_pos = '0;
                        if ((r_phase == trd_pkg::PH_FIRST) &&
                            (i_rx_byte != {{(trd_pkg::BYTE_W-trd_pkg::CFG_W){1'b0}}, r_cfg_addr}))
                        begin
                            n_phase = trd_pkg::PH_HUNT;
                        end else begin
                            if (r_phase == trd_pkg::PH_FIRST) begin
                                n_records = w_count_eff - trd_pkg::CFG_W'(1);
                            end else if (r_records != '0) begin
                                n_records = r_records - trd_pkg::CFG_W'(1);
                            end
                            o_cmd.frame_end = (n_records == '0);
                            o_cmd.arm = (i_rx_byte <
                                         trd_pkg::BYTE_W'(trd_pkg::MAX_RECEIVERS));
                            n_phase = (n_records == '0) ? trd_pkg::PH_HUNT : trd_pkg::PH_NEXT;
                        end
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sv/trd_datapath.sv @@
// trd_datapath: word assembly buffer, record hold registers and output register
// depends on trd_pkg
`default_nettype none
module trd_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic [trd_pkg::BYTE_W-1:0]        i_rx_byte,
    input  wire trd_pkg::t_dp_cmd                  i_cmd,
    output      trd_pkg::t_dp_status               o_status,
    input  wire logic                              i_stall,
    output      logic                              o_valid,
    output      logic [trd_pkg::ADDR_W-1:0]        o_receiver_address,
    output      logic [trd_pkg::OUT_IDX_W-1:0]     o_word_index,
    output      logic signed [trd_pkg::VALUE_W-1:0] o_word_value,
    output      logic [trd_pkg::BYTE_W-1:0]        o_buttons,
    output      logic                              o_last_of_record,
    output      logic                              o_last_of_frame
);

    logic [trd_pkg::LOW7_W-1:0] r_low;
    logic [trd_pkg::WORD_W-1:0] r_words [trd_pkg::WORDS_PER_RECORD];
    logic [trd_pkg::BYTE_W-1:0] r_button;
    logic [trd_pkg::ADDR_W-1:0] r_addr;
    logic                       r_frame_end;
    logic [trd_pkg::CNT_W-1:0]  r_count;
    logic [trd_pkg::WIDX_W-1:0] w_idx;
    logic                       w_last_rec;
    logic                       r_out_valid;

    assign w_idx      = trd_pkg::WIDX_W'(trd_pkg::WORDS_PER_RECORD - int'(r_count));
    assign w_last_rec = (r_count == trd_pkg::CNT_W'(1));

    assign o_status.emit_pending = (r_count != '0);
    assign o_status.out_free     = !r_out_valid || !i_stall;
    assign o_valid               = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_low) begin
            r_low <= i_rx_byte[trd_pkg::LOW7_W-1:0];
        end
        if (i_cmd.write_word) begin
            r_words[i_cmd.word_idx] <= {i_rx_byte[trd_pkg::LOW7_W-1:0], r_low};
        end
        if (i_cmd.load_button) begin
            r_button <= i_rx_byte;
        end
        if (i_cmd.arm) begin
            r_addr      <= i_rx_byte[trd_pkg::ADDR_W-1:0];
            r_frame_end <= i_cmd.frame_end;
        end
        if (i_cmd.emit) begin
            o_receiver_address <= r_addr;
            o_word_index       <= trd_pkg::OUT_IDX_W'(w_idx);
            o_word_value       <= {r_words[w_idx], 2'b00};
            o_buttons          <= r_button;
            o_last_of_record   <= w_last_rec;
            o_last_of_frame    <= w_last_rec && r_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.arm) begin
                r_count <= trd_pkg::CNT_W'(trd_pkg::WORDS_PER_RECORD);
            end else if (i_cmd.emit) begin
                r_count <= r_count - trd_pkg::CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/tracker_record_deframer_unit.sv @@
// tracker_record_deframer_unit: top level, joins controller and datapath
// depends on trd_pkg, trd_ctrl, trd_datapath
// a word enters the output register in the emit state after its byte, once the output is free
// each byte is followed by an emit state; a held output stalls more bytes only if a word waits
// each accepted address byte of a valid record releases twelve words, the first on that byte
// reset: synchronous active low, clears control state and sets registers to defaults; no sweep
`default_nettype none
module tracker_record_deframer_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output      logic                               o_stall,
    input  wire logic [trd_pkg::BYTE_W-1:0]         i_rx_byte,
    output      logic                               o_valid,
    input  wire logic                               i_stall,
    output      logic [trd_pkg::ADDR_W-1:0]         o_receiver_address,
    output      logic [trd_pkg::OUT_IDX_W-1:0]      o_word_index,
    output      logic signed [trd_pkg::VALUE_W-1:0] o_word_value,
    output      logic [trd_pkg::BYTE_W-1:0]         o_buttons,
    output      logic                               o_last_of_record,
    output      logic                               o_last_of_frame,
    input  wire logic                               i_cfg_valid,
    output      logic                               o_cfg_ready,
    input  wire logic [trd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [trd_pkg::CFG_W-1:0]          i_cfg_data
);

    trd_pkg::t_dp_cmd    w_cmd;
    trd_pkg::t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    trd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    trd_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_rx_byte          (i_rx_byte),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_receiver_address (o_receiver_address),
        .o_word_index       (o_word_index),
        .o_word_value       (o_word_value),
        .o_buttons          (o_buttons),
        .o_last_of_record   (o_last_of_record),
        .o_last_of_frame    (o_last_of_frame)
    );

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// tb_top: self-checking bench for tracker_record_deframer_unit; a word scoreboard class
// follows the byte stream, predicts every released word and checks it field by field
// depends on trd_pkg and the deframer rtl

module tb_top;
    import trd_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          RESET_CYCLES = 11;
    localparam int          HOLD_OFF     = 6;
    localparam int          RECORD_BYTES = 2 * WORDS_PER_RECORD + 2;
    localparam int          PHASE_ITEMS  = 55;
    localparam int          SETTINGS_CNT = 7;
    localparam int          MAX_PRINTS   = 60;
    localparam int          FULL_FRAME   = 1 << 20;
    localparam longint      TIMEOUT_NS   = 5_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

    typedef struct packed {
        logic [ADDR_W-1:0]         addr;
        logic [OUT_IDX_W-1:0]      idx;
        logic signed [VALUE_W-1:0] value;
        logic [BYTE_W-1:0]         buttons;
        logic                      last_rec;
        logic                      last_frame;
    } t_word;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_EVERY_THIRD,
        RX_RANDOM,
        RX_LONG
    } t_rx_mode;

    class t_word_scoreboard;
        t_phase           link_phase;
        int unsigned      byte_pos;
        logic [4:0]       records_left;
        logic [6:0]       low_hold;
        logic [WORD_W-1:0] words [WORDS_PER_RECORD];
        logic [7:0]       button_hold;
        int unsigned      words_to_send;
        logic [7:0]       addr_hold;
        bit               frame_end_hold;
        logic [CFG_W-1:0] exp_addr;
        logic [CFG_W-1:0] rcv_cnt;
        t_word            expected_words[$];
        int               errors;

        function new();
            link_phase     = PH_HUNT;
            byte_pos       = 0;
            records_left   = '0;
            low_hold       = '0;
            button_hold    = '0;
            words_to_send  = 0;
            addr_hold      = '0;
            frame_end_hold = 1'b0;
            exp_addr       = CFG_W'(1);
            rcv_cnt        = CFG_W'(1);
            errors         = 0;
            foreach (words[i]) words[i] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_EXPECTED_ADDR) begin
                exp_addr = data;
            end else if (idx == CFG_RECEIVER_CNT) begin
                rcv_cnt = data;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // advances the deframer by one byte; returns 0 only for a byte the hunt drops
        function bit note_byte(logic [7:0] b);
            bit          taken;
            bit          frame_done;
            int unsigned k;
            t_word       w;
            taken = 1'b1;
            if (link_phase == PH_HUNT) begin
                if (b[7]) begin
                    low_hold   = b[6:0];
                    byte_pos   = 1;
                    link_phase = PH_FIRST;
                end else begin
                    taken = 1'b0;
                end
            end else if (byte_pos < 2 * WORDS_PER_RECORD) begin
                if (byte_pos % 2 == 0) begin
                    low_hold = b[6:0];
                end else begin
                    words[byte_pos / 2] = {b[6:0], low_hold};
                end
                byte_pos++;
            end else if (byte_pos == 2 * WORDS_PER_RECORD) begin
                button_hold = b;
                byte_pos++;
            end else begin
                byte_pos = 0;
                if (link_phase == PH_FIRST && b != {3'b000, exp_addr}) begin
                    link_phase = PH_HUNT;
                end else begin
                    if (link_phase == PH_FIRST) begin
                        records_left = (rcv_cnt == 0) ? 5'd0 : rcv_cnt - 5'd1;
                    end else if (records_left != 0) begin
                        records_left = records_left - 5'd1;
                    end
                    frame_done = (records_left == 0);
                    if (b < MAX_RECEIVERS) begin
                        words_to_send  = WORDS_PER_RECORD;
                        addr_hold      = b;
                        frame_end_hold = frame_done;
                    end
                    link_phase = frame_done ? PH_HUNT : PH_NEXT;
                end
            end
            if (words_to_send != 0) begin
                k = WORDS_PER_RECORD - words_to_send;
                words_to_send--;
                w.addr       = addr_hold[ADDR_W-1:0];
                w.idx        = OUT_IDX_W'(k);
                w.value      = {words[k], 2'b00};
                w.buttons    = button_hold;
                w.last_rec   = (k == WORDS_PER_RECORD - 1);
                w.last_frame = w.last_rec && frame_end_hold;
                expected_words.push_back(w);
                taken = 1'b1;
            end
            return taken;
        endfunction

        task report(input string what);
            errors++;
            if (errors <= MAX_PRINTS) $display("%0t mismatch: %s", $time, what);
        endtask

        task check_word(input t_word got);
            t_word want;
            if (expected_words.size() == 0) begin
                report($sformatf("word with nothing expected: addr %0d index %0d",
                                 got.addr, got.idx));
                return;
            end
            want = expected_words.pop_front();
            if (got.addr !== want.addr)
                report($sformatf("receiver_address %0h, want %0h", got.addr, want.addr));
            if (got.idx !== want.idx)
                report($sformatf("word_index %0h, want %0h", got.idx, want.idx));
            if (got.value !== want.value)
                report($sformatf("word_value %0h, want %0h (index %0d)",
                                 got.value, want.value, want.idx));
            if (got.buttons !== want.buttons)
                report($sformatf("buttons %0h, want %0h", got.buttons, want.buttons));
            if (got.last_rec !== want.last_rec)
                report($sformatf("last_of_record %0b, want %0b (index %0d)",
                                 got.last_rec, want.last_rec, want.idx));
            if (got.last_frame !== want.last_frame)
                report($sformatf("last_of_frame %0b, want %0b (index %0d)",
                                 got.last_frame, want.last_frame, want.idx));
        endtask

        task finish_check();
            if (expected_words.size() != 0)
                report($sformatf("%0d words never came", expected_words.size()));
        endtask
    endclass

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_valid     = 1'b0;
    logic                         o_stall;
    logic [BYTE_W-1:0]            i_rx_byte   = '0;
    logic                         o_valid;
    logic                         i_stall     = 1'b0;
    logic [ADDR_W-1:0]            o_receiver_address;
    logic [OUT_IDX_W-1:0]         o_word_index;
    logic signed [VALUE_W-1:0]    o_word_value;
    logic [BYTE_W-1:0]            o_buttons;
    logic                         o_last_of_record;
    logic                         o_last_of_frame;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_W-1:0]             i_cfg_data  = '0;

    t_word_scoreboard sb = new();
    t_word          seen_word;
    int             items_done = 0;
    int             burst_left = 4;
    t_rx_mode       rx_mode = RX_FREE;
    int unsigned    rx_mode_left = 0;
    int unsigned    rx_tick = 0;

    tracker_record_deframer_unit DUT (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // result side: check accepted words, stall on a pattern of its own
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen_word.addr       = o_receiver_address;
            seen_word.idx        = o_word_index;
            seen_word.value      = o_word_value;
            seen_word.buttons    = o_buttons;
            seen_word.last_rec   = o_last_of_record;
            seen_word.last_frame = o_last_of_frame;
            sb.check_word(seen_word);
        end
        rx_tick <= rx_tick + 1;
        if (rx_mode_left == 0) begin
            rx_mode      <= t_rx_mode'($urandom_range(0, 3));
            rx_mode_left <= $urandom_range(16, 160);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_FREE:        i_stall <= 1'b0;
            RX_EVERY_THIRD: i_stall <= (rx_tick % 3) == 0;
            RX_RANDOM:      i_stall <= $urandom_range(0, 1);
            default:        i_stall <= (rx_tick % 32) < 12;
        endcase
    end

    function automatic logic [7:0] rand_data_byte();
        if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'h7F;
            2:       return 8'h80;
            default: return 8'hFF;
        endcase
    endfunction

    function automatic logic [7:0] pick_addr();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind < 14) return 8'($urandom_range(0, MAX_RECEIVERS - 1));
        if (kind < 17) return 8'($urandom_range(MAX_RECEIVERS, 31));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        if (sb.note_byte(b)) items_done++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 16);
        end
    endtask

    task automatic drain_words();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (HOLD_OFF) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_record(input bit opener, input logic [7:0] addr, input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            if (i == RECORD_BYTES - 1) begin
                b = addr;
            end else begin
                b = rand_data_byte();
            end
            if (i == 0 && opener) b[7] = 1'b1;
            send_byte(b);
        end
    endtask

    // cut bounds the bytes sent, so a frame can break off anywhere
    task automatic send_frame(input bit good, input int cut);
        int         nrec;
        int         left;
        int         n;
        logic [7:0] addr;
        nrec = (sb.rcv_cnt == 0) ? 1 : int'(sb.rcv_cnt);
        left = cut;
        for (int r = 0; r < nrec && left > 0; r++) begin
            if (r != 0) begin
                addr = pick_addr();
            end else if (good) begin
                addr = {3'b000, sb.exp_addr};
            end else begin
                addr = {3'b000, sb.exp_addr} ^ 8'($urandom_range(1, 255));
            end
            n = (left < RECORD_BYTES) ? left : RECORD_BYTES;
            send_record(r == 0, addr, n);
            left -= n;
            if (r == 0 && !good) left = 0;
        end
    endtask

    task automatic resync();
        while (sb.link_phase != PH_HUNT) send_byte(8'($urandom_range(0, 127)));
    endtask

    initial begin
        logic [7:0]       opening [RECORD_BYTES];
        logic [CFG_W-1:0] ea;
        logic [CFG_W-1:0] rc;
        int               kind;
        int               phase_goal;
        opening = '{8'h80, 8'h3F, 8'hFF, 8'h7F, 8'h00, 8'h40, 8'h7F, 8'h3F,
                    8'h01, 8'h00, 8'h00, 8'h01, 8'hAA, 8'hD5, 8'h55, 8'h2A,
                    8'h7F, 8'h7F, 8'h00, 8'h00, 8'h80, 8'hC0, 8'h7F, 8'hBF,
                    8'hFF, 8'h01};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hunt drops, then a record of extreme words at the reset settings
        send_byte(8'h00);
        send_byte(8'h7F);
        foreach (opening[i]) send_byte(opening[i]);
        send_byte(8'h00);
        send_byte(8'hFF);

        for (int p = 0; p < SETTINGS_CNT; p++) begin
            drain_words();
            case (p)
                0:       begin ea = 5'd0;  rc = 5'd4;  end
                1:       begin ea = 5'd31; rc = 5'd1;  end
                2:       begin ea = 5'd7;  rc = 5'd3;  end
                3:       begin ea = 5'd22; rc = 5'd0;  end
                4:       begin ea = 5'd13; rc = 5'd2;  end
                5:       begin ea = 5'd1;  rc = 5'd1;  end
                default: begin
                    ea = 5'($urandom_range(0, 31));
                    rc = 5'($urandom_range(1, 5));
                end
            endcase
            write_reg(CFG_EXPECTED_ADDR, ea);
            write_reg(CFG_RECEIVER_CNT, rc);
            if (p == 2) write_reg(CFG_SPARE, 5'($urandom_range(0, 31)));
            phase_goal = items_done + PHASE_ITEMS;
            while (items_done < phase_goal) begin
                kind = $urandom_range(0, 99);
                if (kind < 65) begin
                    resync();
                    repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 127)));
                    send_frame($urandom_range(0, 9) != 0, FULL_FRAME);
                end else if (kind < 80) begin
                    repeat ($urandom_range(1, 8)) send_byte(rand_data_byte());
                end else begin
                    resync();
                    send_frame($urandom_range(0, 3) != 0,
                               $urandom_range(1, 2 * RECORD_BYTES));
                end
            end
        end

        drain_words();
        repeat (4 * HOLD_OFF) @(posedge i_clk);
        sb.finish_check();
        if (sb.errors == 0) begin
            $display("** tracker_record_deframer_unit: PASSED **");
        end else begin
            $display("** tracker_record_deframer_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("** tracker_record_deframer_unit: FAILED **");
        $finish;
    end

endmodule
